// ===== rtl/core/hid_key_report_queue_unit_assert.svh =====
// Assertion macros for the keyboard report queue.
// Depends on nothing; taken in by the top level with `include.
`ifndef HID_KEY_REPORT_QUEUE_UNIT_ASSERT_SVH
`define HID_KEY_REPORT_QUEUE_UNIT_ASSERT_SVH

// Check that a condition implies another one in the same cycle
`define HKRQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the following cycle
`define HKRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hkrq_pkg.sv =====
// Shared types and constants of the keyboard report queue.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package hkrq_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned TIMER_W = 8;

  // Idle timer value after reset
  localparam logic [TIMER_W-1:0] IDLE_RESET = 8'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND_KEY  = 2'd0,
    KIND_IDLE_TICK = 2'd1,
    KIND_EP_READY  = 2'd2,
    KIND_NONE      = 2'd3
  } kind_e;

  // One queued report: modifier in the high byte, key code in the low byte
  typedef struct packed {
    logic [BYTE_W-1:0] modifier;
    logic [BYTE_W-1:0] key;
  } report_t;

endpackage

// ===== rtl/core/hkrq_item_if.sv =====
// Input channel of the keyboard report queue: one item per handshake.
// Depends on hkrq_pkg.
`timescale 1ns / 1ps

interface hkrq_item_if;
  import hkrq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] modifier;
  logic [BYTE_W-1:0] key_code;

  modport source (output valid, kind, modifier, key_code, input ready);
  modport sink   (input valid, kind, modifier, key_code, output ready);

endinterface

// ===== rtl/core/hkrq_result_if.sv =====
// Result channel of the keyboard report queue: one item per handshake.
// Depends on hkrq_pkg.
`timescale 1ns / 1ps

interface hkrq_result_if;
  import hkrq_pkg::*;

  logic               valid;
  logic               ready;
  logic               report_valid;
  logic [BYTE_W-1:0]  report_modifier;
  logic [BYTE_W-1:0]  report_key;
  logic               accepted;
  logic [LEVEL_W-1:0] queue_level;

  modport source (output valid, report_valid, report_modifier, report_key, accepted,
                  queue_level, input ready);
  modport sink   (input valid, report_valid, report_modifier, report_key, accepted,
                  queue_level, output ready);

endinterface

// ===== rtl/core/hid_key_report_queue_unit.sv =====
// Keyboard report queue: a ring of QUEUE_DEPTH two-byte reports held in one
// synchronous memory, with an idle repeat timer. A send-key item queues the key
// report and a release report when fewer than QUEUE_DEPTH-1 reports are queued,
// writing one memory entry per cycle, in ST_IDLE then ST_PUSH_REL. Idle ticks,
// endpoint-ready pops, empty items and refused send-keys go from ST_IDLE (queue
// update and memory access) straight to ST_EMIT (loads the result register once
// it is free). Exactly one result item leaves per input item. The result sits in
// an output register, so the next input item is taken while a result still
// waits. idle_rate may only be written while the block is idle. Depends on
// hkrq_pkg, hkrq_item_if, hkrq_result_if and the assertion macro header.
`timescale 1ns / 1ps

module hid_key_report_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hkrq_pkg::BYTE_W-1:0] cfg_wdata_i,
  hkrq_item_if.sink                 item_i,
  hkrq_result_if.source             result_o
);
  import hkrq_pkg::*;

  `include "hid_key_report_queue_unit_assert.svh"

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH_REL,
    ST_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     rd_q, rd_d;
  logic [IDX_W-1:0]     wr_q, wr_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TIMER_W-1:0]   timer_q, timer_d;
  logic [BYTE_W-1:0]    idle_rate_q;
  logic                 res_acc_q, res_acc_d;
  logic                 res_pop_q, res_pop_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_rvalid_q, out_rvalid_d;
  report_t              out_report_q, out_report_d;
  logic                 out_acc_q, out_acc_d;
  logic [LEVEL_W-1:0]   out_level_q, out_level_d;

  logic                 item_fire;
  kind_e                item_kind;
  logic [IDX_W-1:0]     rd_next, wr_next;
  logic [31:0]          cnt_ext;

  // Report memory
  report_t              mem [QUEUE_DEPTH];
  logic                 mem_we;
  report_t              mem_wdata;
  logic                 mem_re;
  report_t              mem_rdata_q;

  assign item_fire = item_i.valid && item_i.ready;
  assign item_kind = kind_e'(item_i.kind);
  assign rd_next   = (rd_q == LAST_SLOT) ? '0 : rd_q + IDX_W'(1);
  assign wr_next   = (wr_q == LAST_SLOT) ? '0 : wr_q + IDX_W'(1);
  assign cnt_ext   = 32'(cnt_q);

  assign item_i.ready             = (state_q == ST_IDLE);
  assign result_o.valid           = out_valid_q;
  assign result_o.report_valid    = out_rvalid_q;
  assign result_o.report_modifier = out_report_q.modifier;
  assign result_o.report_key      = out_report_q.key;
  assign result_o.accepted        = out_acc_q;
  assign result_o.queue_level     = out_level_q;

  // Update queue pointers, timer and result register
  always_comb begin
    state_d      = state_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    cnt_d        = cnt_q;
    timer_d      = timer_q;
    res_acc_d    = res_acc_q;
    res_pop_d    = res_pop_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_rvalid_d = out_rvalid_q;
    out_report_d = out_report_q;
    out_acc_d    = out_acc_q;
    out_level_d  = out_level_q;
    mem_we       = 1'b0;
    mem_wdata    = '0;
    mem_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (item_fire) begin
          res_acc_d = 1'b0;
          res_pop_d = 1'b0;
          state_d   = ST_EMIT;
          unique case (item_kind)
            KIND_SEND_KEY: begin
              // Queue the key now and the release in the next cycle
              if (cnt_q < CNT_LIMIT) begin
                mem_we    = 1'b1;
                mem_wdata = '{modifier: item_i.modifier, key: item_i.key_code};
                wr_d      = wr_next;
                cnt_d     = cnt_q + CNT_W'(1);
                res_acc_d = 1'b1;
                state_d   = ST_PUSH_REL;
              end
            end
            KIND_IDLE_TICK: begin
              // Expire on one or zero, reload, and repeat a release if empty
              if (timer_q <= TIMER_W'(1)) begin
                timer_d = idle_rate_q;
                if (cnt_q == '0) begin
                  mem_we = 1'b1;
                  wr_d   = wr_next;
                  cnt_d  = cnt_q + CNT_W'(1);
                end
              end else begin
                timer_d = timer_q - TIMER_W'(1);
              end
            end
            KIND_EP_READY: begin
              // Read the oldest report; data arrives in the next cycle
              if (cnt_q != '0) begin
                mem_re    = 1'b1;
                rd_d      = rd_next;
                cnt_d     = cnt_q - CNT_W'(1);
                res_pop_d = 1'b1;
              end
            end
            KIND_NONE: begin
            end
          endcase
        end
      end
      ST_PUSH_REL: begin
        mem_we  = 1'b1;
        wr_d    = wr_next;
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // Load the result register once it is free
        if (!out_valid_q || result_o.ready) begin
          out_valid_d  = 1'b1;
          out_rvalid_d = res_pop_q;
          out_report_d = res_pop_q ? mem_rdata_q : '0;
          out_acc_d    = res_acc_q;
          out_level_d  = cnt_ext[LEVEL_W-1:0];
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, configuration and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_q         <= '0;
      wr_q         <= '0;
      cnt_q        <= '0;
      timer_q      <= IDLE_RESET;
      idle_rate_q  <= '0;
      res_acc_q    <= 1'b0;
      res_pop_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_rvalid_q <= 1'b0;
      out_report_q <= '0;
      out_acc_q    <= 1'b0;
      out_level_q  <= '0;
    end else begin
      state_q      <= state_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      cnt_q        <= cnt_d;
      timer_q      <= timer_d;
      res_acc_q    <= res_acc_d;
      res_pop_q    <= res_pop_d;
      out_valid_q  <= out_valid_d;
      out_rvalid_q <= out_rvalid_d;
      out_report_q <= out_report_d;
      out_acc_q    <= out_acc_d;
      out_level_q  <= out_level_d;
      if (cfg_we_i) begin
        idle_rate_q <= cfg_wdata_i;
      end
    end
  end

  // Write one entry and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_q] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[rd_q];
    end
  end

  `HKRQ_ASSERT_SAME(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_FULL,
                    "report count beyond queue depth")
  `HKRQ_ASSERT_SAME(a_ptr_match, clk_i, rst_ni, (cnt_q == '0) || (cnt_q == CNT_FULL),
                    wr_q == rd_q, "read and write slots disagree with count")
  `HKRQ_ASSERT_NEXT(a_one_item, clk_i, rst_ni, item_fire, state_q != ST_IDLE,
                    "item taken while previous item still in work")

endmodule

// ===== dv/tb_hid_key_report_queue_unit.sv =====
// Testbench of the keyboard report queue: directed and random items, each result
// checked against a mirror of the report ring and idle timer held in a small class.
// Depends on hkrq_pkg, hkrq_item_if, hkrq_result_if and hid_key_report_queue_unit.
`timescale 1ns / 1ps

module tb_hid_key_report_queue_unit;
  import hkrq_pkg::*;

  localparam int unsigned QDEPTH        = 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned NUM_PHASES    = 4;

  // What one item is owed on the result channel
  typedef struct {
    logic               report_valid;
    logic [BYTE_W-1:0]  report_modifier;
    logic [BYTE_W-1:0]  report_key;
    logic               accepted;
    logic [LEVEL_W-1:0] queue_level;
  } outcome_t;

  // Mirror of the report ring and idle timer, plus the outcomes still owed
  class report_queue_mirror;
    report_t            slots [QDEPTH];
    int unsigned        head;
    int unsigned        tail;
    int unsigned        fill;
    logic [TIMER_W-1:0] countdown;
    logic [BYTE_W-1:0]  idle_rate;
    report_t            last_popped;
    outcome_t           owed [$];
    int unsigned        errors;

    function new();
      head        = 0;
      tail        = 0;
      fill        = 0;
      countdown   = IDLE_RESET;
      idle_rate   = '0;
      last_popped = '0;
      errors      = 0;
    endfunction

    function void push_slot(report_t r);
      slots[tail] = r;
      tail        = (tail + 1) % QDEPTH;
      fill++;
    endfunction

    // Advance the mirror by one accepted item and note what it owes
    function void note_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] modifier,
                            logic [BYTE_W-1:0] key_code);
      outcome_t o;
      report_t  r;
      o          = '{default: '0};
      r.modifier = modifier;
      r.key      = key_code;
      case (kind_e'(kind))
        KIND_SEND_KEY: begin
          // queue key and release only while two slots are left
          if (fill < QDEPTH - 1) begin
            push_slot(r);
            push_slot('0);
            o.accepted = 1'b1;
          end
        end
        KIND_IDLE_TICK: begin
          if (countdown <= 1) begin
            if (fill == 0) begin
              push_slot('0);
            end
            countdown = idle_rate;
          end else begin
            countdown--;
          end
        end
        KIND_EP_READY: begin
          if (fill > 0) begin
            last_popped       = slots[head];
            head              = (head + 1) % QDEPTH;
            fill--;
            o.report_valid    = 1'b1;
            o.report_modifier = last_popped.modifier;
            o.report_key      = last_popped.key;
          end
        end
        default: begin
        end
      endcase
      o.queue_level = LEVEL_W'(fill);
      owed.push_back(o);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Check one accepted result against the oldest owed outcome
    function void check_result(outcome_t got);
      outcome_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual valid %0b mod %0h key %0h",
                 $time, got.report_valid, got.report_modifier, got.report_key);
        $display("%0t: unexpected result: actual acc %0b level %0d",
                 $time, got.accepted, got.queue_level);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("report_valid", 8'(want.report_valid), 8'(got.report_valid));
      compare_field("report_modifier", want.report_modifier, got.report_modifier);
      compare_field("report_key", want.report_key, got.report_key);
      compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
      compare_field("queue_level", 8'(want.queue_level), 8'(got.queue_level));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          tick_heavy = 1'b0;
  int unsigned quiet     = 0;

  report_queue_mirror mirror = new();

  hkrq_item_if   item_bus ();
  hkrq_result_if result_bus ();

  hid_key_report_queue_unit #(
    .QUEUE_DEPTH (QDEPTH)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_bus),
    .result_o    (result_bus)
  );

  always #1 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every accepted result
  always @(posedge clk) begin : watch_results
    outcome_t seen;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      seen.report_valid    = result_bus.report_valid;
      seen.report_modifier = result_bus.report_modifier;
      seen.report_key      = result_bus.report_key;
      seen.accepted        = result_bus.accepted;
      seen.queue_level     = result_bus.queue_level;
      mirror.check_result(seen);
    end
  end

  // Give up when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("hid_key_report_queue_unit test failed");
        $finish;
      end
    end
  end

  // Offer one item after a random gap and hold it until taken; enter and leave
  // at a falling edge with valid not yet driven there
  task automatic send_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] modifier,
                           logic [BYTE_W-1:0] key_code);
    while ($urandom_range(99) < gap_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.valid    <= 1'b1;
    item_bus.kind     <= kind;
    item_bus.modifier <= modifier;
    item_bus.key_code <= key_code;
    @(posedge clk);
    while (!item_bus.ready) begin
      @(posedge clk);
    end
    mirror.note_item(kind, modifier, key_code);
    @(negedge clk);
  endtask

  // Hold the sender until every owed result is back, then let the block go quiet
  task automatic drain_and_settle();
    item_bus.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (mirror.owed.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_idle_rate(logic [BYTE_W-1:0] rate);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(negedge clk);
    cfg_we           <= 1'b0;
    mirror.idle_rate  = rate;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned ph_gap   [NUM_PHASES] = '{0, 45, 0, 26};
    int unsigned ph_stall [NUM_PHASES] = '{0, 0, 45, 26};
    int unsigned ph_rate  [NUM_PHASES] = '{0, 1, 130, 255};
    int unsigned ph_items [NUM_PHASES] = '{80, 80, 170, 80};
    bit          ph_ticks [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0};
    int unsigned roll;
    logic [KIND_W-1:0] kind;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    item_bus.valid      = 1'b0;
    item_bus.kind       = KIND_NONE;
    item_bus.modifier   = '0;
    item_bus.key_code   = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty pop, ignored kind, fill to the drop point, timer expiry
    // with a busy queue, drain past empty, then expiry on an empty queue
    write_idle_rate(8'd3);
    send_item(KIND_EP_READY, 8'hff, 8'hff);
    send_item(KIND_NONE, 8'hff, 8'hff);
    send_item(KIND_SEND_KEY, 8'hff, 8'hff);
    send_item(KIND_SEND_KEY, 8'h00, 8'h00);
    send_item(KIND_SEND_KEY, 8'h55, 8'haa);
    send_item(KIND_SEND_KEY, 8'haa, 8'h55);
    send_item(KIND_SEND_KEY, 8'h12, 8'h34);
    repeat (5) send_item(KIND_IDLE_TICK, 8'h00, 8'h00);
    repeat (9) send_item(KIND_EP_READY, 8'h00, 8'h00);
    repeat (3) send_item(KIND_IDLE_TICK, 8'hff, 8'hff);
    send_item(KIND_EP_READY, 8'hff, 8'hff);

    // Random phases, each with its own idle rate and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_idle_rate(BYTE_W'(ph_rate[p]));
      gap_pct    = ph_gap[p];
      stall_pct  = ph_stall[p];
      tick_heavy = ph_ticks[p];
      for (int i = 0; i < ph_items[p]; i++) begin
        if (i == ph_items[p] / 2 || $urandom_range(99) < 2) begin
          drain_and_settle();
        end
        roll = $urandom_range(99);
        if (tick_heavy) begin
          // long tick runs so that a large idle rate still expires
          kind = (roll < 85) ? KIND_IDLE_TICK : (roll < 90) ? KIND_SEND_KEY : KIND_EP_READY;
        end else if (roll < 30) begin
          kind = KIND_SEND_KEY;
        end else if (roll < 48) begin
          kind = KIND_IDLE_TICK;
        end else if (roll < 95) begin
          kind = KIND_EP_READY;
        end else begin
          kind = KIND_NONE;
        end
        send_item(kind, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
      end
    end

    drain_and_settle();
    if (mirror.errors == 0) begin
      $display("hid_key_report_queue_unit test passed");
    end else begin
      $display("hid_key_report_queue_unit test failed");
    end
    $finish;
  end

endmodule
